// File: design/pwmc_pkg.sv
// Shared constants and types for the PWM period and duty calculator.
`default_nettype none
package pwmc_pkg;
	localparam int unsigned REF_CLOCK_HZ   = 40000000;
	localparam int unsigned COUNTER_BITS   = 16;
	localparam int unsigned PRESCALE_STEPS = 256;
	localparam int unsigned RES_MIN        = 2;
	localparam int unsigned RES_MAX        = 16;
	localparam int unsigned RES_RESET      = 8;

	localparam int unsigned NUM_W = 33;
	localparam int unsigned DEN_W = 32;

	localparam logic [23:0] FREQ_MIN =
		24'(REF_CLOCK_HZ / PRESCALE_STEPS / (2 ** COUNTER_BITS) + 1);
	localparam logic [23:0] FREQ_MAX = 24'(REF_CLOCK_HZ / 4);
	localparam logic [NUM_W-1:0] CLK_NUM = NUM_W'(REF_CLOCK_HZ);
	localparam logic [NUM_W-1:0] CLK_HI  = NUM_W'(REF_CLOCK_HZ / (2 ** COUNTER_BITS));

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_DUTY  = 2'd1;
	localparam logic [1:0] OP_RES   = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_FRQ = 2'd1;
	localparam logic [1:0] ST_BAD_RES = 2'd2;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;
endpackage
`default_nettype wire

// File: design/pwmc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pwmc_div import pwmc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_req_t         req,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   sh;
	logic             ge;

	assign sh = {rem_q, quo_q[NUM_W-1]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(sh - {1'b0, den_q}) : sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// File: design/pwm_period_duty_calculator.sv
// Top level: PWM timer prescaler search and per-channel compare calculation.
// Busy after accept: resolution sets and rejects emit directly; a duty update runs
// one compare divide; a write runs prescaler and period divides, then one compare
// divide per enabled channel on the shared divider, one result beat per channel.
// One item at a time; in_ready is high only while the sequencer is idle.
// Reset: async active low; all channels to 8-bit resolution, zero, disabled.
`default_nettype none
module pwm_period_duty_calculator import pwmc_pkg::*; #(
	parameter int NUM_CHANNELS = 18
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [4:0]  channel,
	input  wire logic [15:0] value,
	input  wire logic [23:0] frequency,
	input  wire logic [4:0]  resolution,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       out_channel,
	output logic [15:0]      compare_value,
	output logic [15:0]      period_reload,
	output logic [7:0]       prescaler,
	output logic [15:0]      stored_value,
	output logic             channel_on,
	output logic [1:0]       status,
	output logic             last
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_DIV1  = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_DIV2S = 4'd4;
	localparam logic [3:0] S_DIV2  = 4'd5;
	localparam logic [3:0] S_SCAN  = 4'd6;
	localparam logic [3:0] S_CMUL  = 4'd7;
	localparam logic [3:0] S_CDIVS = 4'd8;
	localparam logic [3:0] S_CDIV  = 4'd9;
	localparam logic [3:0] S_EMIT  = 4'd10;

	logic [3:0]  state_q;
	logic [1:0]  op_q;
	logic [15:0] val_q;
	logic [23:0] freq_q;
	logic [4:0]  res_in_q;
	logic [4:0]  idx_q;
	logic [5:0]  scan_q;
	logic        scan_mode_q;
	logic [7:0]  pre_q;
	logic [16:0] period_q;
	logic [31:0] m_q;
	logic [32:0] prod_q;
	logic [15:0] cmp_q;
	logic [1:0]  stat_q;

	logic [4:0]  res_mem_q [NUM_CHANNELS];
	logic [15:0] val_mem_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] en_q;

	div_req_t    div_req;
	logic        div_done;
	logic [32:0] div_quo;

	logic [4:0]  cur_res;
	logic [4:0]  old_res;
	logic [16:0] fs;
	logic [15:0] clamped;
	logic [31:0] rescaled;
	logic        freq_ok;
	logic        res_ok;
	logic        can_load;
	logic [NUM_CHANNELS-1:0] above;

	pwmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		cur_res = res_mem_q[idx_q];
		old_res = (cur_res > 5'(RES_MAX)) ? 5'(RES_MAX) : cur_res;
		fs      = (17'd1 << old_res) - 17'd1;
		clamped = ({1'b0, val_q} > fs) ? fs[15:0] : val_q;
		if (res_in_q >= old_res)
			rescaled = {16'd0, val_mem_q[idx_q]} << (res_in_q - old_res);
		else
			rescaled = {16'd0, val_mem_q[idx_q]} >> (old_res - res_in_q);
		freq_ok  = (freq_q >= FREQ_MIN) && (freq_q <= FREQ_MAX);
		res_ok   = (res_in_q >= 5'(RES_MIN)) && (res_in_q <= 5'(RES_MAX));
		can_load = !out_valid || out_ready;
		above    = en_q >> ({1'b0, idx_q} + 6'd1);
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = prod_q;
		div_req.den   = {15'd0, fs};
		unique case (state_q)
			S_EXEC: begin
				div_req.start = (op_q == OP_WRITE) && freq_ok;
				div_req.num   = CLK_HI;
				div_req.den   = {8'd0, freq_q};
			end
			S_DIV2S: begin
				div_req.start = 1'b1;
				div_req.num   = CLK_NUM;
				div_req.den   = m_q;
			end
			S_CDIVS: div_req.start = 1'b1;
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_mode_q <= 1'b0;
			out_valid   <= 1'b0;
			period_q    <= '0;
			pre_q       <= '0;
			en_q        <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				res_mem_q[i] <= 5'(RES_RESET);
				val_mem_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready && state_q != S_EMIT)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && operation != OP_NONE && {27'd0, channel} < NUM_CHANNELS)
						state_q <= S_EXEC;
					scan_mode_q <= 1'b0;
				end
				S_EXEC: begin
					unique case (op_q)
						OP_WRITE: begin
							if (freq_ok) begin
								en_q[idx_q]      <= 1'b1;
								val_mem_q[idx_q] <= clamped;
								state_q          <= S_DIV1;
							end else begin
								state_q <= S_EMIT;
							end
						end
						OP_DUTY: begin
							val_mem_q[idx_q] <= clamped;
							state_q          <= S_CMUL;
						end
						default: begin
							if (res_ok) begin
								res_mem_q[idx_q] <= res_in_q;
								val_mem_q[idx_q] <= rescaled[15:0];
							end
							state_q <= S_EMIT;
						end
					endcase
				end
				S_DIV1: begin
					if (div_done) begin
						pre_q   <= (|div_quo[32:8]) ? 8'(PRESCALE_STEPS - 1) : div_quo[7:0];
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_DIV2S;
				S_DIV2S: state_q <= S_DIV2;
				S_DIV2: begin
					if (div_done) begin
						period_q    <= div_quo[16:0];
						scan_mode_q <= 1'b1;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_q >= 6'(NUM_CHANNELS))
						state_q <= S_IDLE;
					else if (en_q[scan_q[4:0]])
						state_q <= S_CMUL;
				end
				S_CMUL:  state_q <= S_CDIVS;
				S_CDIVS: state_q <= S_CDIV;
				S_CDIV:  if (div_done) state_q <= S_EMIT;
				S_EMIT: begin
					if (can_load) begin
						out_valid <= 1'b1;
						state_q   <= scan_mode_q ? S_SCAN : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q     <= operation;
				idx_q    <= channel;
				val_q    <= value;
				freq_q   <= frequency;
				res_in_q <= resolution;
				cmp_q    <= '0;
				stat_q   <= ST_OK;
			end
			S_EXEC: begin
				if (op_q == OP_WRITE && !freq_ok)
					stat_q <= ST_BAD_FRQ;
				else if (op_q == OP_RES && !res_ok)
					stat_q <= ST_BAD_RES;
				scan_q <= '0;
			end
			S_MUL: m_q <= {23'd0, 9'({1'b0, pre_q} + 9'd1)} * {8'd0, freq_q};
			S_SCAN: begin
				if (scan_q < 6'(NUM_CHANNELS)) begin
					idx_q  <= scan_q[4:0];
					scan_q <= scan_q + 6'd1;
				end
			end
			S_CMUL: prod_q <= {17'd0, val_mem_q[idx_q]} * {16'd0, period_q};
			S_CDIV: if (div_done) cmp_q <= div_quo[15:0];
			S_EMIT: begin
				if (can_load) begin
					out_channel   <= idx_q;
					compare_value <= cmp_q;
					period_reload <= (period_q != '0) ? 16'(period_q - 17'd1) : 16'd0;
					prescaler     <= pre_q;
					stored_value  <= val_mem_q[idx_q];
					channel_on    <= en_q[idx_q];
					status        <= stat_q;
					last          <= scan_mode_q ? (above == '0) : 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: tb/sv/pwmc_checker.sv
// Checker: watches both channels, predicts PWM timer results and compares them.
`timescale 1ns / 1ps
module pwmc_checker import pwmc_pkg::*; #(
	parameter int NUM_CHANNELS = 18
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [4:0]  channel,
	input  wire logic [15:0] value,
	input  wire logic [23:0] frequency,
	input  wire logic [4:0]  resolution,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [4:0]  out_channel,
	input  wire logic [15:0] compare_value,
	input  wire logic [15:0] period_reload,
	input  wire logic [7:0]  prescaler,
	input  wire logic [15:0] stored_value,
	input  wire logic        channel_on,
	input  wire logic [1:0]  status,
	input  wire logic        last,
	output int               errors,
	output int               pending
);
	typedef struct packed {
		logic [4:0]  ch;
		logic [15:0] cmp;
		logic [15:0] reload;
		logic [7:0]  psc;
		logic [15:0] stored;
		logic        on;
		logic [1:0]  st;
		logic        lst;
	} pwm_beat_t;

	pwm_beat_t   beat_q[$];
	logic [4:0]  ch_res[NUM_CHANNELS];
	logic [15:0] ch_val[NUM_CHANNELS];
	logic        ch_en[NUM_CHANNELS];
	logic [16:0] tim_per;
	logic [7:0]  tim_psc;

	assign pending = beat_q.size();

	function automatic logic [16:0] full_scale(int c);
		int r;
		r = ch_res[c];
		if (r > RES_MAX) r = RES_MAX;
		return 17'((64'd1 << r) - 1);
	endfunction

	function automatic pwm_beat_t make_beat(int c, logic [63:0] cmp, logic [1:0] st,
			logic lst);
		pwm_beat_t b;
		b.ch = 5'(c);
		b.cmp = cmp[15:0];
		b.reload = (tim_per != 0) ? 16'(tim_per - 1) : 16'd0;
		b.psc = tim_psc;
		b.stored = ch_val[c];
		b.on = ch_en[c];
		b.st = st;
		b.lst = lst;
		return b;
	endfunction

	function automatic logic [63:0] compare_of(int c);
		logic [63:0] den;
		den = 64'(full_scale(c));
		if (den == 0) return 0;
		return (64'(ch_val[c]) * 64'(tim_per)) / den;
	endfunction

	task automatic predict_timer(logic [1:0] op, int c, logic [15:0] v,
			logic [23:0] f, logic [4:0] r);
		logic [63:0] per, p, vc;
		int n, k, oldr;
		logic [31:0] sv;
		if (c >= NUM_CHANNELS || op > OP_RES) return;
		if (op == OP_WRITE) begin
			if (f < FREQ_MIN || f > FREQ_MAX) begin
				beat_q.push_back(make_beat(c, 0, ST_BAD_FRQ, 1'b1));
				return;
			end
			ch_en[c] = 1'b1;
			vc = 64'(v);
			if (vc > 64'(full_scale(c))) vc = 64'(full_scale(c));
			ch_val[c] = vc[15:0];
			p = 0;
			per = 64'(REF_CLOCK_HZ) / 64'(f);
			while (per > 64'hFFFF && p < PRESCALE_STEPS - 1) begin
				p++;
				per = (64'(REF_CLOCK_HZ) / (p + 1)) / 64'(f);
			end
			tim_per = per[16:0];
			tim_psc = p[7:0];
			n = 0;
			for (int i = 0; i < NUM_CHANNELS; i++) if (ch_en[i]) n++;
			k = 0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (ch_en[i]) begin
					beat_q.push_back(make_beat(i, compare_of(i), ST_OK, k == n - 1));
					k++;
				end
			end
		end else if (op == OP_DUTY) begin
			vc = 64'(v);
			if (vc > 64'(full_scale(c))) vc = 64'(full_scale(c));
			ch_val[c] = vc[15:0];
			beat_q.push_back(make_beat(c, compare_of(c), ST_OK, 1'b1));
		end else if (r < RES_MIN || r > RES_MAX) begin
			beat_q.push_back(make_beat(c, 0, ST_BAD_RES, 1'b1));
		end else begin
			oldr = ch_res[c];
			if (oldr > RES_MAX) oldr = RES_MAX;
			sv = 32'(ch_val[c]);
			if (r >= oldr) sv = sv << (r - oldr);
			else sv = sv >> (oldr - r);
			ch_res[c] = r;
			ch_val[c] = sv[15:0];
			beat_q.push_back(make_beat(c, 0, ST_OK, 1'b1));
		end
	endtask

	task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch: expected %0d actual %0d", $time, name, exp, act);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			ch_res[i] = 5'(RES_RESET);
			ch_val[i] = 0;
			ch_en[i] = 0;
		end
		tim_per = 0;
		tim_psc = 0;
	end

	always @(posedge clk) begin
		pwm_beat_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (beat_q.size() == 0) begin
					$display("%0t: unexpected beat: expected none actual channel %0d",
						$time, out_channel);
					errors++;
				end else begin
					e = beat_q.pop_front();
					check_field("out_channel", 16'(e.ch), 16'(out_channel));
					check_field("compare_value", e.cmp, compare_value);
					check_field("period_reload", e.reload, period_reload);
					check_field("prescaler", 16'(e.psc), 16'(prescaler));
					check_field("stored_value", e.stored, stored_value);
					check_field("channel_on", 16'(e.on), 16'(channel_on));
					check_field("status", 16'(e.st), 16'(status));
					check_field("last", 16'(e.lst), 16'(last));
				end
			end
			if (in_valid && in_ready)
				predict_timer(operation, channel, value, frequency, resolution);
		end
	end
endmodule

// File: tb/sv/tb.sv
// Testbench top: stimulus, clock, reset and verdict for the PWM calculator.
`timescale 1ns / 1ps
module tb;
	import pwmc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [4:0]  channel;
	logic [15:0] value;
	logic [23:0] frequency;
	logic [4:0]  resolution;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  out_channel;
	logic [15:0] compare_value;
	logic [15:0] period_reload;
	logic [7:0]  prescaler;
	logic [15:0] stored_value;
	logic        channel_on;
	logic [1:0]  status;
	logic        last;
	int          errors;
	int          pending;
	int          cycles;

	localparam int CYCLE_LIMIT = 5000000;

	pwm_period_duty_calculator dut (.*);
	pwmc_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic int rand_gap();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver stall
	initial begin
		int g;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			@(posedge clk);
			g = rand_gap();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	task automatic send_beat(logic [1:0] op, logic [4:0] ch, logic [15:0] v,
			logic [23:0] f, logic [4:0] r);
		int g;
		g = rand_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		channel <= ch;
		value <= v;
		frequency <= f;
		resolution <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_freq();
		case ($urandom_range(0, 5))
			0: return 24'($urandom);
			1: return 24'($urandom_range(1, 30));
			2: return 24'($urandom_range(30, 2000));
			3: return 24'($urandom_range(2000, 200000));
			4: return 24'($urandom_range(200000, FREQ_MAX + 5));
			default: return 24'($urandom_range(FREQ_MIN - 1, FREQ_MIN + 2));
		endcase
	endfunction

	initial begin
		logic [1:0] op;
		logic [4:0] ch;
		arst_n = 0;
		in_valid = 0;
		operation = 0;
		channel = 0;
		value = 0;
		frequency = 0;
		resolution = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// before any write: zero period
		send_beat(OP_DUTY, 5'd0, 16'hFFFF, 24'd0, 5'd0);
		send_beat(OP_RES, 5'd1, 16'd0, 24'd0, 5'd1);
		send_beat(OP_RES, 5'd1, 16'd0, 24'd0, 5'd17);
		send_beat(OP_WRITE, 5'd2, 16'd100, FREQ_MIN - 1, 5'd0);
		send_beat(OP_WRITE, 5'd2, 16'd100, FREQ_MAX + 1, 5'd0);
		send_beat(OP_WRITE, 5'd2, 16'hFFFF, FREQ_MIN, 5'd0);
		send_beat(OP_WRITE, 5'd3, 16'd0, FREQ_MAX, 5'd0);
		send_beat(OP_WRITE, 5'd17, 16'd128, 24'd1000, 5'd31);
		send_beat(OP_WRITE, 5'd18, 16'd5, 24'd1000, 5'd8);
		send_beat(OP_NONE, 5'd0, 16'd5, 24'd1000, 5'd8);
		send_beat(OP_WRITE, 5'd31, 16'd5, 24'hFFFFFF, 5'd8);
		send_beat(OP_RES, 5'd2, 16'd0, 24'd0, 5'd16);
		send_beat(OP_RES, 5'd2, 16'd0, 24'd0, 5'd2);
		send_beat(OP_DUTY, 5'd4, 16'd77, 24'd0, 5'd0);
		send_beat(OP_RES, 5'd17, 16'd0, 24'd0, 5'd16);
		send_beat(OP_DUTY, 5'd17, 16'hFFFF, 24'd0, 5'd0);
		send_beat(OP_WRITE, 5'd0, 16'd1, 24'd40000, 5'd0);
		for (int i = 0; i < 380; i++) begin
			if (i == 190) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			op = 2'($urandom_range(0, 2));
			if ($urandom_range(0, 19) == 0) op = OP_NONE;
			ch = 5'($urandom_range(0, 17));
			if ($urandom_range(0, 19) == 0) ch = 5'($urandom_range(18, 31));
			send_beat(op, ch, ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 300)), rand_freq(),
				($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(2, 16)));
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
